// ----- sv/bcdrtc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdrtc_pkg
// Shared types, register offsets and BCD helpers for the BCD calendar RTC.
// ----------------------------------------------------------------------------
package bcdrtc_pkg;

  localparam int WINDOW_BYTES_DEF = 128;
  localparam int LANES            = 8;

  // request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // configuration register indexes
  localparam logic CFG_TPS = 1'b0;
  localparam logic CFG_DPM = 1'b1;

  localparam logic [7:0] TPS_RESET = 8'd8;
  localparam logic [4:0] DPM_RESET = 5'd28;

  // register map
  localparam logic [7:0] OFF_SUBSEC     = 8'h00;
  localparam logic [7:0] OFF_SEC        = 8'h02;
  localparam logic [7:0] OFF_MIN        = 8'h04;
  localparam logic [7:0] OFF_HOUR       = 8'h06;
  localparam logic [7:0] OFF_DAY        = 8'h0A;
  localparam logic [7:0] OFF_MONTH      = 8'h0C;
  localparam logic [7:0] OFF_YEAR       = 8'h0E;
  localparam logic [7:0] OFF_SEC_ALARM  = 8'h10;
  localparam logic [7:0] OFF_MIN_ALARM  = 8'h12;
  localparam logic [7:0] OFF_HOUR_ALARM = 8'h14;
  localparam logic [7:0] OFF_CTRL1      = 8'h22;
  localparam logic [7:0] OFF_CTRL2      = 8'h24;

  localparam logic [7:0] CTRL1_AIE   = 8'h01;
  localparam logic [7:0] CTRL1_PIE   = 8'h04;
  localparam logic [7:0] CTRL2_START = 8'h01;
  localparam logic [7:0] ALARM_EN    = 8'h80;
  localparam logic [7:0] ALARM_VAL   = 8'h7F;

  localparam logic [7:0] SEC_WRAP   = 8'd60;
  localparam logic [7:0] MIN_WRAP   = 8'd60;
  localparam logic [7:0] HOUR_WRAP  = 8'd24;
  localparam logic [7:0] MONTH_LAST = 8'd12;
  localparam logic [7:0] CENTURY    = 8'd100;
  localparam logic [6:0] YEAR_LAST  = 7'd99;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  offset;
    logic [3:0]  access_bytes;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        alarm_event;
    logic        periodic_event;
  } out_item_t;

  // register bytes with fixed meaning, kept in flops
  typedef struct packed {
    logic [7:0] subsec;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] sec_alarm;
    logic [7:0] min_alarm;
    logic [7:0] hour_alarm;
    logic [7:0] ctrl1;
    logic [7:0] ctrl2;
  } shd_t;

  typedef struct packed {
    logic tick;
    logic reload;
  } tm_cmd_t;

  typedef struct packed {
    logic [7:0] subsec;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic       alarm;
    logic       periodic;
  } tm_pub_t;

  // binary to BCD, truncated to 8 bits; v/10 as (v*205)>>11, exact below 1029
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    r    = v - ({q, 3'b000} + {2'b00, q, 1'b0});
    return {q[3:0], r[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'd0, b[3:0]};
  endfunction

  function automatic logic is_special(input logic [7:0] a);
    return (a == OFF_SUBSEC) || (a == OFF_SEC) || (a == OFF_MIN) ||
           (a == OFF_HOUR) || (a == OFF_DAY) || (a == OFF_MONTH) ||
           (a == OFF_YEAR) || (a == OFF_SEC_ALARM) || (a == OFF_MIN_ALARM) ||
           (a == OFF_HOUR_ALARM) || (a == OFF_CTRL1) || (a == OFF_CTRL2);
  endfunction

endpackage

// ----- sv/bcd_calendar_rtc_with_alarm_top.sv -----
// ----------------------------------------------------------------------------
// bcd_calendar_rtc_with_alarm_top
// BCD calendar real-time clock with alarm behind a byte register window.
// ----------------------------------------------------------------------------
// Takes one word per cycle (read, write or tick) while the output is not stalled
// and returns one result word for each through the staging and output registers. The window
// sits in eight byte-wide banks, one per byte lane, each with one write and
// one registered read port, so an eight-byte access touches every bank once;
// a bank read issued on acceptance picks up a write from the word ahead of it.
// Calendar, alarm and control bytes live in flops. Unwritten window bytes read
// as zero through per-byte valid bits cleared by reset; no clearing pass.
module bcd_calendar_rtc_with_alarm_top #(
  parameter int WINDOW_BYTES = bcdrtc_pkg::WINDOW_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bcdrtc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bcdrtc_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata
);
  import bcdrtc_pkg::*;

  localparam int NROWS = (WINDOW_BYTES + LANES - 1) / LANES;
  localparam int RW    = $clog2(NROWS);
  localparam logic [8:0] WIN = 9'(WINDOW_BYTES);

  logic      s1_vld_r, out_vld_r;
  in_item_t  s1_item_r;
  out_item_t out_item_r, out_item_nxt;
  logic [7:0] tps_r;
  logic [4:0] dpm_r;
  shd_t      shd_r, shd_wr, shd_nxt;

  logic       adv, acc, wr_go, tick_act, tick_go, cal;
  logic [3:0] n_eff;
  logic [7:0] lane_addr [LANES];
  logic [LANES-1:0] lane_on;
  logic [63:0] rd;
  tm_cmd_t    tm_cmd;
  tm_pub_t    tm_pub;

  logic [RW-1:0] bk_raddr [LANES];
  logic [RW-1:0] bk_waddr [LANES];
  logic [7:0]    bk_wdata [LANES];
  logic [7:0]    bk_rdata [LANES];
  logic [LANES-1:0] bk_we;

  // handshake
  assign adv      = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || adv;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      dpm_r <= DPM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TPS: tps_r <= cfg_wdata;
        CFG_DPM: dpm_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // byte lanes of the staged word
  always_comb begin
    n_eff = (s1_item_r.access_bytes > 4'd8) ? 4'd8 : s1_item_r.access_bytes;
    for (int i = 0; i < LANES; i++) begin
      lane_addr[i] = {1'b0, s1_item_r.offset} + 8'(i);
      lane_on[i]   = (4'(i) < n_eff) && ({1'b0, lane_addr[i]} < WIN);
    end
  end

  // read assembly
  always_comb begin
    rd = 64'd0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_on[i]) begin
        case (lane_addr[i])
          OFF_SUBSEC:     rd[8*i +: 8] = shd_r.subsec;
          OFF_SEC:        rd[8*i +: 8] = shd_r.seconds;
          OFF_MIN:        rd[8*i +: 8] = shd_r.minutes;
          OFF_HOUR:       rd[8*i +: 8] = shd_r.hours;
          OFF_DAY:        rd[8*i +: 8] = shd_r.day;
          OFF_MONTH:      rd[8*i +: 8] = shd_r.month;
          OFF_YEAR:       rd[8*i +: 8] = shd_r.year;
          OFF_SEC_ALARM:  rd[8*i +: 8] = shd_r.sec_alarm;
          OFF_MIN_ALARM:  rd[8*i +: 8] = shd_r.min_alarm;
          OFF_HOUR_ALARM: rd[8*i +: 8] = shd_r.hour_alarm;
          OFF_CTRL1:      rd[8*i +: 8] = shd_r.ctrl1;
          OFF_CTRL2:      rd[8*i +: 8] = shd_r.ctrl2;
          default:        rd[8*i +: 8] = bk_rdata[lane_addr[i][2:0]];
        endcase
      end
    end
  end

  // fixed-register writes; flag any calendar byte
  assign wr_go = adv && (s1_item_r.req_type == REQ_WRITE);

  always_comb begin
    logic [7:0] wb;
    shd_wr = shd_r;
    cal    = 1'b0;
    wb     = 8'h00;
    if (wr_go) begin
      for (int i = 0; i < LANES; i++) begin
        wb = s1_item_r.write_data[8*i +: 8];
        if (lane_on[i]) begin
          case (lane_addr[i])
            OFF_SUBSEC:     shd_wr.subsec = wb;
            OFF_SEC:        begin shd_wr.seconds = wb; cal = 1'b1; end
            OFF_MIN:        begin shd_wr.minutes = wb; cal = 1'b1; end
            OFF_HOUR:       begin shd_wr.hours   = wb; cal = 1'b1; end
            OFF_DAY:        begin shd_wr.day     = wb; cal = 1'b1; end
            OFF_MONTH:      begin shd_wr.month   = wb; cal = 1'b1; end
            OFF_YEAR:       begin shd_wr.year    = wb; cal = 1'b1; end
            OFF_SEC_ALARM:  shd_wr.sec_alarm  = wb;
            OFF_MIN_ALARM:  shd_wr.min_alarm  = wb;
            OFF_HOUR_ALARM: shd_wr.hour_alarm = wb;
            OFF_CTRL1:      shd_wr.ctrl1 = wb;
            OFF_CTRL2:      shd_wr.ctrl2 = wb;
            default: ;
          endcase
        end
      end
    end
  end

  assign tick_act = (s1_item_r.req_type == REQ_TICK) &&
                    ((shd_r.ctrl2 & CTRL2_START) != 8'h00);
  assign tick_go  = adv && tick_act;

  assign tm_cmd.tick   = tick_go;
  assign tm_cmd.reload = wr_go && cal;

  bcdrtc_time u_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .tps     (tps_r),
    .dpm     (dpm_r),
    .cmd     (tm_cmd),
    .shd_cur (shd_r),
    .shd_wr  (shd_wr),
    .pub     (tm_pub)
  );

  // refresh the calendar bytes on a running tick
  always_comb begin
    shd_nxt = shd_wr;
    if (tick_go) begin
      shd_nxt.subsec  = tm_pub.subsec;
      shd_nxt.seconds = tm_pub.seconds;
      shd_nxt.minutes = tm_pub.minutes;
      shd_nxt.hours   = tm_pub.hours;
      shd_nxt.day     = tm_pub.day;
      shd_nxt.month   = tm_pub.month;
      shd_nxt.year    = tm_pub.year;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shd_r <= '0;
    end else begin
      shd_r <= shd_nxt;
    end
  end

  always_comb begin
    out_item_nxt.read_data      = (s1_item_r.req_type == REQ_READ) ? rd : 64'd0;
    out_item_nxt.alarm_event    = tick_act && tm_pub.alarm;
    out_item_nxt.periodic_event = tick_act && tm_pub.periodic;
  end

  // bank addressing: bank b serves the lane whose address ends in b
  always_comb begin
    logic [2:0] li;
    logic [7:0] wa;
    logic [2:0] ri;
    logic [7:0] ra;
    li = 3'd0;
    wa = 8'd0;
    ri = 3'd0;
    ra = 8'd0;
    for (int b = 0; b < LANES; b++) begin
      li = 3'(b) - s1_item_r.offset[2:0];
      wa = {1'b0, s1_item_r.offset} + {5'd0, li};
      bk_we[b]    = wr_go && lane_on[li] && !is_special(wa);
      bk_waddr[b] = wa[RW+2:3];
      bk_wdata[b] = s1_item_r.write_data[{li, 3'b000} +: 8];
      ri = 3'(b) - in_data.offset[2:0];
      ra = {1'b0, in_data.offset} + {5'd0, ri};
      bk_raddr[b] = ra[RW+2:3];
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    bcdrtc_bank #(
      .NROWS (NROWS)
    ) u_bank (
      .clk   (clk),
      .rst_n (rst_n),
      .re    (acc),
      .raddr (bk_raddr[b]),
      .we    (bk_we[b]),
      .waddr (bk_waddr[b]),
      .wdata (bk_wdata[b]),
      .rdata (bk_rdata[b])
    );
  end

endmodule

// ----- sv/bcdrtc_bank.sv -----
// ----------------------------------------------------------------------------
// bcdrtc_bank
// One byte lane of the register window: one write and one registered read
// per cycle, per-entry valid bits so unwritten bytes read as zero.
// ----------------------------------------------------------------------------
module bcdrtc_bank #(
  parameter int NROWS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     re,
  input  logic [$clog2(NROWS)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(NROWS)-1:0] waddr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0]       mem [NROWS];
  logic [NROWS-1:0] vld_r;
  logic [7:0]       rd_r;
  logic             rvld_r;
  logic             fwd;

  assign fwd = we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // pass a same-cycle write straight to the read side
    if (re) begin
      rd_r <= fwd ? wdata : mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= fwd || vld_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rd_r : 8'h00;

endmodule

// ----- sv/bcdrtc_time.sv -----
// ----------------------------------------------------------------------------
// bcdrtc_time
// Binary calendar counters, tick divider and alarm compare.
// ----------------------------------------------------------------------------
module bcdrtc_time (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          tps,
  input  logic [4:0]          dpm,
  input  bcdrtc_pkg::tm_cmd_t cmd,
  input  bcdrtc_pkg::shd_t    shd_cur,
  input  bcdrtc_pkg::shd_t    shd_wr,
  output bcdrtc_pkg::tm_pub_t pub
);
  import bcdrtc_pkg::*;

  logic [7:0]  sec_r, min_r, hour_r, day_r, mon_r, div_r;
  logic [15:0] year_r;
  logic [6:0]  ylo_r;
  logic [5:0]  sub_r;

  logic [7:0]  sec_nxt, min_nxt, hour_nxt, day_nxt, mon_nxt, div_inc;
  logic [15:0] year_nxt;
  logic [6:0]  ylo_nxt;
  logic [5:0]  sub_inc;
  logic        sec_done;
  logic        any_en, ok_s, ok_m, ok_h;
  logic [7:0]  yv;

  always_comb begin
    div_inc  = div_r + 8'd1;
    sub_inc  = sub_r + 6'd1;
    sec_done = div_inc >= tps;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    ylo_nxt  = ylo_r;
    // ripple the carry up the calendar
    if (sec_done) begin
      sec_nxt = sec_r + 8'd1;
      if (sec_nxt >= SEC_WRAP) begin
        sec_nxt = 8'd0;
        min_nxt = min_r + 8'd1;
        if (min_nxt >= MIN_WRAP) begin
          min_nxt  = 8'd0;
          hour_nxt = hour_r + 8'd1;
          if (hour_nxt >= HOUR_WRAP) begin
            hour_nxt = 8'd0;
            day_nxt  = day_r + 8'd1;
            if (day_nxt > {3'b000, dpm}) begin
              day_nxt = 8'd1;
              mon_nxt = mon_r + 8'd1;
              if (mon_nxt > MONTH_LAST) begin
                mon_nxt  = 8'd1;
                year_nxt = year_r + 16'd1;
                ylo_nxt  = ((year_r == 16'hFFFF) || (ylo_r == YEAR_LAST)) ?
                           7'd0 : ylo_r + 7'd1;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    any_en = ((shd_cur.sec_alarm | shd_cur.min_alarm | shd_cur.hour_alarm) & ALARM_EN)
             != 8'h00;
    ok_s = ((shd_cur.sec_alarm & ALARM_EN) == 8'h00) ||
           (from_bcd(shd_cur.sec_alarm & ALARM_VAL) == sec_nxt);
    ok_m = ((shd_cur.min_alarm & ALARM_EN) == 8'h00) ||
           (from_bcd(shd_cur.min_alarm & ALARM_VAL) == min_nxt);
    ok_h = ((shd_cur.hour_alarm & ALARM_EN) == 8'h00) ||
           (from_bcd(shd_cur.hour_alarm & ALARM_VAL) == hour_nxt);
  end

  always_comb begin
    pub.subsec   = {2'b00, sub_inc};
    pub.seconds  = to_bcd(sec_nxt);
    pub.minutes  = to_bcd(min_nxt);
    pub.hours    = to_bcd(hour_nxt);
    pub.day      = to_bcd(day_nxt);
    pub.month    = to_bcd(mon_nxt);
    pub.year     = to_bcd({1'b0, ylo_nxt});
    pub.alarm    = sec_done && any_en && ok_s && ok_m && ok_h &&
                   ((shd_cur.ctrl1 & CTRL1_AIE) != 8'h00);
    pub.periodic = sec_done && ((shd_cur.ctrl1 & CTRL1_PIE) != 8'h00);
  end

  assign yv = from_bcd(shd_wr.year);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= 8'd0;
      min_r  <= 8'd0;
      hour_r <= 8'd0;
      day_r  <= 8'd0;
      mon_r  <= 8'd0;
      year_r <= 16'd0;
      ylo_r  <= 7'd0;
      sub_r  <= 6'd0;
      div_r  <= 8'd0;
    end else if (cmd.tick) begin
      sub_r  <= sub_inc;
      div_r  <= sec_done ? 8'd0 : div_inc;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
      ylo_r  <= ylo_nxt;
    end else if (cmd.reload) begin
      sec_r  <= from_bcd(shd_wr.seconds);
      min_r  <= from_bcd(shd_wr.minutes);
      hour_r <= from_bcd(shd_wr.hours);
      day_r  <= from_bcd(shd_wr.day);
      mon_r  <= from_bcd(shd_wr.month);
      year_r <= {8'd0, yv};
      ylo_r  <= (yv >= CENTURY) ? 7'(yv - CENTURY) : yv[6:0];
    end
  end

endmodule
